/* rtl/gda_pkg.sv */
// ----------------------------------------------------------------------------
// gda_pkg: shared types and constants for the Gregorian date arithmetic core
// Holds field widths, operation codes, controller states and the
// controller-to-datapath command structures.
// ----------------------------------------------------------------------------
package gda_pkg;

  localparam int unsigned MAX_YEAR = 9999;
  localparam int unsigned YW = 14;
  localparam int unsigned MW = 4;
  localparam int unsigned DW = 5;
  localparam int unsigned AW = 16;
  localparam int unsigned FW = 22;
  localparam int unsigned NW = 24;
  localparam int unsigned CW = 32;

  localparam logic [YW-1:0] TOP_YEAR =
    (MAX_YEAR < 16383) ? YW'(MAX_YEAR) : YW'(16383);

  typedef enum logic [1:0] {
    OP_ADD_DAYS   = 2'd0,
    OP_ADD_MONTHS = 2'd1,
    OP_ADD_YEARS  = 2'd2,
    OP_DIFF       = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLAMP,
    ST_DOY,
    ST_DAY_YEAR,
    ST_DAY_MONTH,
    ST_MON_DIV,
    ST_FIX,
    ST_DN_A,
    ST_DN_B,
    ST_DIFF,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic clamp;
    logic doy_step;
    logic yr_step;
    logic mo_step;
    logic div_step;
    logic fix;
    logic dn_b;
    logic diff;
    logic done;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic doy_end;
    logic yr_end;
    logic mo_end;
  } sts_t;

  // year / 100 by reciprocal multiply, exact for every 14-bit year
  function automatic logic [7:0] div100(input logic [YW-1:0] y);
    logic [27:0] prod;
    prod   = 28'(y) * 28'd5243;
    div100 = prod[26:19];
  endfunction

  function automatic logic is_leap(input logic [YW-1:0] y);
    logic [7:0]    q;
    logic [YW-1:0] cent;
    q       = div100(y);
    cent    = YW'(q) * YW'(100);
    // century years are leap only when the century count is a multiple of 4
    is_leap = (y[1:0] == 2'b00) && ((cent != y) || (q[1:0] == 2'b00));
  endfunction

  function automatic logic [DW-1:0] mdays(input logic [YW-1:0] y,
                                           input logic [MW-1:0] m);
    logic [DW-1:0] r;
    r = DW'(31);
    unique case (m)
      4'd2:                      r = is_leap(y) ? DW'(29) : DW'(28);
      4'd4, 4'd6, 4'd9, 4'd11:   r = DW'(30);
      default:                   r = DW'(31);
    endcase
    mdays = r;
  endfunction

endpackage

/* rtl/gregorian_date_arithmetic_core.sv */
// ----------------------------------------------------------------------------
// gregorian_date_arithmetic_core: Gregorian date add and day difference
// Controller and datapath pair; one result word per accepted input word.
// ----------------------------------------------------------------------------
//  channel | handshake        | word
//  input   | start / busy     | in_operation .. in_other_day
//  result  | out_valid strobe | out_result_year .. out_overflow
//
//  Sequencing: add years runs clamp, fix and done; add months adds a
//  divide step before fix; add days steps the clamped base months, then
//  one year per cycle through the years crossed, then the months stepped;
//  difference steps the clamped months of both dates, then subtracts.
//  The result strobe rises in the same cycle that busy drops.
//  Reset: rst_n low clears the controller and the strobe.
//  Stalls: the receiver cannot stall; busy holds off new words.
// ----------------------------------------------------------------------------
module gregorian_date_arithmetic_core (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic [1:0]              in_operation,
  input  logic [gda_pkg::YW-1:0]  in_base_year,
  input  logic [gda_pkg::MW-1:0]  in_base_month,
  input  logic [gda_pkg::DW-1:0]  in_base_day,
  input  logic [gda_pkg::AW-1:0]  in_amount,
  input  logic [gda_pkg::YW-1:0]  in_other_year,
  input  logic [gda_pkg::MW-1:0]  in_other_month,
  input  logic [gda_pkg::DW-1:0]  in_other_day,
  output logic                    out_valid,
  output logic [gda_pkg::YW-1:0]  out_result_year,
  output logic [gda_pkg::MW-1:0]  out_result_month,
  output logic [gda_pkg::DW-1:0]  out_result_day,
  output logic [gda_pkg::FW-1:0]  out_day_difference,
  output logic                    out_date_valid,
  output logic                    out_overflow
);
  import gda_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequence the steps
  gda_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  // hold operands, step the calendar, register the result word
  gda_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_operation       (in_operation),
    .in_base_year       (in_base_year),
    .in_base_month      (in_base_month),
    .in_base_day        (in_base_day),
    .in_amount          (in_amount),
    .in_other_year      (in_other_year),
    .in_other_month     (in_other_month),
    .in_other_day       (in_other_day),
    .out_valid          (out_valid),
    .out_result_year    (out_result_year),
    .out_result_month   (out_result_month),
    .out_result_day     (out_result_day),
    .out_day_difference (out_day_difference),
    .out_date_valid     (out_date_valid),
    .out_overflow       (out_overflow)
  );

endmodule

/* rtl/gda_ctrl.sv */
// ----------------------------------------------------------------------------
// gda_ctrl: sequencing controller
// Walks each operation through its datapath steps and raises the strobe.
// ----------------------------------------------------------------------------
module gda_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  gda_pkg::sts_t sts,
  output gda_pkg::cmd_t cmd
);
  import gda_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = (state_r != ST_IDLE);
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CLAMP;
        end
      end
      ST_CLAMP: begin
        cmd.clamp = 1'b1;
        unique case (sts.op)
          OP_ADD_DAYS:   state_nxt = ST_DOY;
          OP_ADD_MONTHS: state_nxt = ST_MON_DIV;
          OP_ADD_YEARS:  state_nxt = ST_FIX;
          OP_DIFF:       state_nxt = ST_DN_A;
          default:       state_nxt = ST_DOY;
        endcase
      end
      ST_DOY: begin
        cmd.doy_step = 1'b1;
        if (sts.doy_end) state_nxt = ST_DAY_YEAR;
      end
      ST_DAY_YEAR: begin
        cmd.yr_step = 1'b1;
        if (sts.yr_end) state_nxt = ST_DAY_MONTH;
      end
      ST_DAY_MONTH: begin
        cmd.mo_step = 1'b1;
        if (sts.mo_end) state_nxt = ST_DONE;
      end
      ST_MON_DIV: begin
        cmd.div_step = 1'b1;
        state_nxt    = ST_FIX;
      end
      ST_FIX: begin
        cmd.fix   = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_DN_A: begin
        cmd.doy_step = 1'b1;
        if (sts.doy_end) state_nxt = ST_DN_B;
      end
      ST_DN_B: begin
        cmd.dn_b = 1'b1;
        if (sts.doy_end) state_nxt = ST_DIFF;
      end
      ST_DIFF: begin
        cmd.diff  = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        cmd.done  = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

/* rtl/gda_dp.sv */
// ----------------------------------------------------------------------------
// gda_dp: date datapath
// Registers the operands and steps months and years one per cycle; adds days and years in one step.
// ----------------------------------------------------------------------------
module gda_dp (
  input  logic                    clk,
  input  logic                    rst_n,
  input  gda_pkg::cmd_t           cmd,
  output gda_pkg::sts_t           sts,
  input  logic [1:0]              in_operation,
  input  logic [gda_pkg::YW-1:0]  in_base_year,
  input  logic [gda_pkg::MW-1:0]  in_base_month,
  input  logic [gda_pkg::DW-1:0]  in_base_day,
  input  logic [gda_pkg::AW-1:0]  in_amount,
  input  logic [gda_pkg::YW-1:0]  in_other_year,
  input  logic [gda_pkg::MW-1:0]  in_other_month,
  input  logic [gda_pkg::DW-1:0]  in_other_day,
  output logic                    out_valid,
  output logic [gda_pkg::YW-1:0]  out_result_year,
  output logic [gda_pkg::MW-1:0]  out_result_month,
  output logic [gda_pkg::DW-1:0]  out_result_day,
  output logic [gda_pkg::FW-1:0]  out_day_difference,
  output logic                    out_date_valid,
  output logic                    out_overflow
);
  import gda_pkg::*;

  op_t           op_r;
  logic [YW-1:0] y_r, oy_r;
  logic [MW-1:0] m_r, om_r;
  logic [DW-1:0] d_r, od_r;
  logic [AW-1:0] amt_r;
  logic          valid_r, ovf_r;
  // shared day counter, month index and wide accumulator
  logic [NW-1:0] n_r;
  logic [MW-1:0] i_r;
  logic [CW-1:0] acc_r;
  logic [NW-1:0] dna_r;
  logic          sel_r;

  logic          out_valid_r;
  logic [YW-1:0] oyr_r;
  logic [MW-1:0] omr_r;
  logic [DW-1:0] odr_r;
  logic [FW-1:0] odf_r;
  logic          odv_r, oov_r;

  logic [YW-1:0] cy;
  logic [MW-1:0] cm;
  logic [DW-1:0] cd;
  logic [YW-1:0] cyo;
  logic [MW-1:0] cmo;
  logic [DW-1:0] cdo;
  logic [YW-1:0] ycur;
  logic [MW-1:0] mcur;
  logic [YW-1:0] p;
  logic [7:0]    q100p;
  logic [NW-1:0] dn_base;
  logic [NW-1:0] diy;
  logic [NW-1:0] dim;
  logic [YW-1:0] fy;
  logic [MW-1:0] fm;
  logic [CW-1:0] ysum;
  logic [NW-1:0] dabs;
  logic [CW-1:0] mprod;
  logic [CW-1:0] mq;
  logic [CW-1:0] mrem;

  // clamp helpers
  always_comb begin
    cy = (y_r == '0) ? YW'(1) : ((y_r > TOP_YEAR) ? TOP_YEAR : y_r);
    cm = (m_r == '0) ? MW'(1) : ((m_r > MW'(12)) ? MW'(12) : m_r);
    cd = (d_r == '0) ? DW'(1) : d_r;
    if (cd > mdays(cy, cm)) cd = mdays(cy, cm);
    cyo = (oy_r == '0) ? YW'(1) : ((oy_r > TOP_YEAR) ? TOP_YEAR : oy_r);
    cmo = (om_r == '0) ? MW'(1) : ((om_r > MW'(12)) ? MW'(12) : om_r);
    cdo = (od_r == '0) ? DW'(1) : od_r;
    if (cdo > mdays(cyo, cmo)) cdo = mdays(cyo, cmo);
  end

  assign ycur    = sel_r ? oy_r : y_r;
  assign mcur    = sel_r ? om_r : m_r;
  assign p       = ycur - YW'(1);
  assign q100p   = div100(p);
  // p/400 is the century count over four
  assign dn_base = NW'(365 * 32'(p)) + NW'(p >> 2) - NW'(q100p) + NW'(q100p >> 2);
  assign diy     = is_leap(y_r) ? NW'(366) : NW'(365);
  assign dim     = NW'(mdays(y_r, i_r));
  assign ysum    = CW'(y_r) + CW'(amt_r);
  assign fy      = (op_r == OP_ADD_MONTHS) ? YW'(acc_r) : YW'(ysum);
  assign fm      = (op_r == OP_ADD_MONTHS) ? i_r : m_r;
  assign dabs    = (dna_r > n_r) ? dna_r - n_r : n_r - dna_r;

  // month count / 12: divide by 4 with a shift, then by 3 with a reciprocal
  assign mprod   = CW'(acc_r[17:2]) * CW'(43691);
  assign mq      = CW'(mprod[31:17]);
  assign mrem    = acc_r - mq * CW'(12);

  always_comb begin
    sts.op      = op_r;
    sts.doy_end = (i_r >= mcur);
    sts.yr_end  = (n_r <= diy) || ovf_r;
    sts.mo_end  = ovf_r || (i_r == MW'(12)) || (n_r <= dim);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= op_t'(in_operation);
      y_r     <= in_base_year;
      m_r     <= in_base_month;
      d_r     <= in_base_day;
      amt_r   <= in_amount;
      oy_r    <= in_other_year;
      om_r    <= in_other_month;
      od_r    <= in_other_day;
      ovf_r   <= 1'b0;
      sel_r   <= 1'b0;
    end
    if (cmd.clamp) begin
      valid_r <= (y_r != '0) && (y_r <= TOP_YEAR) && (m_r != '0) &&
                 (m_r <= MW'(12)) && (d_r != '0) && (d_r <= mdays(y_r, m_r));
      y_r  <= cy;  m_r  <= cm;  d_r  <= cd;
      oy_r <= cyo; om_r <= cmo; od_r <= cdo;
      i_r  <= MW'(1);
      n_r  <= NW'(cd);
      // month count: y*12 + (m-1) + amount, split into year and month next
      acc_r <= CW'(cy) * CW'(12) + CW'(cm - MW'(1)) + CW'(amt_r);
    end
    if (cmd.doy_step && !sts.doy_end) begin
      n_r <= n_r + NW'(mdays(ycur, i_r));
      i_r <= i_r + MW'(1);
    end
    if (cmd.doy_step && sts.doy_end) begin
      if (op_r == OP_ADD_DAYS) begin
        n_r <= n_r + NW'(amt_r);
        i_r <= MW'(1);
      end else begin
        // save base day number, restart for the second date
        dna_r <= dn_base + n_r - NW'(1);
        sel_r <= 1'b1;
        i_r   <= MW'(1);
        n_r   <= NW'(od_r);
      end
    end
    if (cmd.yr_step && !sts.yr_end) begin
      n_r <= n_r - diy;
      if (y_r == TOP_YEAR) ovf_r <= 1'b1;
      else y_r <= y_r + YW'(1);
    end
    if (cmd.mo_step && !sts.mo_end) begin
      n_r <= n_r - dim;
      i_r <= i_r + MW'(1);
    end
    if (cmd.mo_step && sts.mo_end) begin
      m_r <= i_r;
      d_r <= DW'(n_r);
    end
    if (cmd.div_step) begin
      acc_r <= mq;
      i_r   <= MW'(mrem) + MW'(1);
    end
    if (cmd.dn_b && !sts.doy_end) begin
      n_r <= n_r + NW'(mdays(ycur, i_r));
      i_r <= i_r + MW'(1);
    end
    if (cmd.dn_b && sts.doy_end) begin
      n_r <= dn_base + n_r - NW'(1);
    end
    if (cmd.fix) begin
      if ((op_r == OP_ADD_MONTHS ? acc_r : ysum) > CW'(TOP_YEAR)) begin
        ovf_r <= 1'b1;
      end else begin
        y_r <= fy;
        m_r <= fm;
        if (d_r > mdays(fy, fm)) d_r <= mdays(fy, fm);
      end
    end
    if (cmd.diff) begin
      n_r <= dabs;
    end
    if (cmd.done) begin
      oyr_r <= ovf_r ? TOP_YEAR : y_r;
      omr_r <= ovf_r ? MW'(12)  : m_r;
      odr_r <= ovf_r ? DW'(31)  : d_r;
      odf_r <= (op_r == OP_DIFF) ?
               ((n_r > NW'(22'h3FFFFF)) ? 22'h3FFFFF : FW'(n_r)) : '0;
      odv_r <= valid_r;
      oov_r <= ovf_r;
    end
  end

  // strobe the result word for one cycle after done
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.done;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_result_year    = oyr_r;
  assign out_result_month   = omr_r;
  assign out_result_day     = odr_r;
  assign out_day_difference = odf_r;
  assign out_date_valid     = odv_r;
  assign out_overflow       = oov_r;

endmodule

/* rtl/gda_chk.sv */
// ----------------------------------------------------------------------------
// gda_chk: port checker
// Watches the handshake and result word of the date core.
// ----------------------------------------------------------------------------
module gda_chk (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    start,
  input logic                    busy,
  input logic                    out_valid,
  input logic [gda_pkg::MW-1:0]  out_result_month,
  input logic                    out_overflow,
  input logic [gda_pkg::FW-1:0]  out_day_difference
);
  import gda_pkg::*;

  // accepted word makes the core busy
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("busy not raised");
  // strobe is a single pulse
  a_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("strobe longer than one cycle");
  // no strobe while idle before
  a_res: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy)) else $error("result without work");
  // overflow saturates to December with no day difference
  a_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_overflow) |-> (out_result_month == MW'(12) &&
    out_day_difference == '0)) else $error("overflow not saturated");

endmodule

bind gregorian_date_arithmetic_core gda_chk u_chk (
  .clk                (clk),
  .rst_n              (rst_n),
  .start              (start),
  .busy               (busy),
  .out_valid          (out_valid),
  .out_result_month   (out_result_month),
  .out_overflow       (out_overflow),
  .out_day_difference (out_day_difference)
);

/* verif/gregorian_date_arithmetic_core_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gregorian_date_arithmetic_core_tb: self-checking bench for the date core
// Drives dates through add days, add months, add years and day difference,
// predicts each result word in the bench and compares it field by field.
// ----------------------------------------------------------------------------
module gregorian_date_arithmetic_core_tb;
  import gda_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned DRAIN_CYCLES   = 400;
  localparam int unsigned DIFF_SAT       = 32'h3FFFFF;

  typedef struct {
    logic [YW-1:0] year;
    logic [MW-1:0] month;
    logic [DW-1:0] day;
    logic [FW-1:0] diff;
    logic          valid;
    logic          ovf;
  } date_word_t;

  logic          clk;
  logic          rst_n;
  logic          start;
  logic          busy;
  logic [1:0]    in_operation;
  logic [YW-1:0] in_base_year;
  logic [MW-1:0] in_base_month;
  logic [DW-1:0] in_base_day;
  logic [AW-1:0] in_amount;
  logic [YW-1:0] in_other_year;
  logic [MW-1:0] in_other_month;
  logic [DW-1:0] in_other_day;
  logic          out_valid;
  logic [YW-1:0] out_result_year;
  logic [MW-1:0] out_result_month;
  logic [DW-1:0] out_result_day;
  logic [FW-1:0] out_day_difference;
  logic          out_date_valid;
  logic          out_overflow;

  date_word_t pending_dates[$];
  int         err_cnt;
  int         idle_cycles;

  gregorian_date_arithmetic_core i_dut (
    .clk, .rst_n, .start, .busy,
    .in_operation, .in_base_year, .in_base_month, .in_base_day, .in_amount,
    .in_other_year, .in_other_month, .in_other_day,
    .out_valid, .out_result_year, .out_result_month, .out_result_day,
    .out_day_difference, .out_date_valid, .out_overflow
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // ---- calendar arithmetic for the predictor ----
  function automatic bit leap_year(int unsigned y);
    return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
  endfunction

  function automatic int unsigned month_days(int unsigned y, int unsigned m);
    case (m)
      2:           return leap_year(y) ? 29 : 28;
      4, 6, 9, 11: return 30;
      default:     return 31;
    endcase
  endfunction

  function automatic int unsigned year_days(int unsigned y);
    return leap_year(y) ? 366 : 365;
  endfunction

  // Pull a raw date into the supported range before any arithmetic.
  function automatic void clamp_date(ref int unsigned y, ref int unsigned m,
                                     ref int unsigned d);
    if (y < 1) y = 1;
    if (y > TOP_YEAR) y = TOP_YEAR;
    if (m < 1) m = 1;
    if (m > 12) m = 12;
    if (d < 1) d = 1;
    if (d > month_days(y, m)) d = month_days(y, m);
  endfunction

  function automatic int unsigned ordinal_day(int unsigned y, int unsigned m,
                                              int unsigned d);
    int unsigned n;
    n = d;
    for (int unsigned i = 1; i < m; i++) n += month_days(y, i);
    return n;
  endfunction

  // Days elapsed since 0001-01-01.
  function automatic int unsigned epoch_day(int unsigned y, int unsigned m,
                                            int unsigned d);
    int unsigned p;
    p = y - 1;
    return 365 * p + p / 4 - p / 100 + p / 400 + ordinal_day(y, m, d) - 1;
  endfunction

  function automatic date_word_t predict_date(op_t op, int unsigned y,
      int unsigned m, int unsigned d, int unsigned amt, int unsigned oy,
      int unsigned om, int unsigned od);
    date_word_t    w;
    int unsigned   n, total, da, db, df;
    bit            ovf;
    ovf = 1'b0;
    df  = 0;
    w.valid = (y >= 1) && (y <= TOP_YEAR) && (m >= 1) && (m <= 12) &&
              (d >= 1) && (d <= month_days(y, m));
    clamp_date(y, m, d);
    case (op)
      OP_ADD_DAYS: begin
        n = ordinal_day(y, m, d) + amt;
        while (n > year_days(y)) begin
          n -= year_days(y);
          y++;
          if (y > TOP_YEAR) begin
            ovf = 1'b1;
            break;
          end
        end
        if (!ovf) begin
          m = 1;
          while (m < 12 && n > month_days(y, m)) begin
            n -= month_days(y, m);
            m++;
          end
          d = n;
        end
      end
      OP_ADD_MONTHS: begin
        total = y * 12 + (m - 1) + amt;
        y = total / 12;
        m = total % 12 + 1;
        if (y > TOP_YEAR) ovf = 1'b1;
        else if (d > month_days(y, m)) d = month_days(y, m);
      end
      OP_ADD_YEARS: begin
        y = y + amt;
        if (y > TOP_YEAR) ovf = 1'b1;
        else if (d > month_days(y, m)) d = month_days(y, m);
      end
      default: begin
        clamp_date(oy, om, od);
        da = epoch_day(y, m, d);
        db = epoch_day(oy, om, od);
        df = (da > db) ? da - db : db - da;
        if (df > DIFF_SAT) df = DIFF_SAT;
      end
    endcase
    if (ovf) begin
      y = TOP_YEAR;
      m = 12;
      d = 31;
    end
    w.year  = YW'(y);
    w.month = MW'(m);
    w.day   = DW'(d);
    w.diff  = FW'(df);
    w.ovf   = ovf;
    return w;
  endfunction

  // ---- stimulus ----
  // Send one word: idle a random gap, raise start, hold until busy is low
  // at an edge, then drop start. The prediction is queued on acceptance.
  task automatic send_date(op_t op, int unsigned y, int unsigned m,
                           int unsigned d, int unsigned amt,
                           int unsigned oy, int unsigned om, int unsigned od);
    int unsigned gap;
    date_word_t  exp_w;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 8);
    // leave start low at the next edge before the next word
    @(posedge clk);
    repeat (gap) @(posedge clk);
    start          <= 1'b1;
    in_operation   <= op;
    in_base_year   <= YW'(y);
    in_base_month  <= MW'(m);
    in_base_day    <= DW'(d);
    in_amount      <= AW'(amt);
    in_other_year  <= YW'(oy);
    in_other_month <= MW'(om);
    in_other_day   <= DW'(od);
    do @(posedge clk); while (busy);
    exp_w = predict_date(op, y & 16'h3FFF, m & 4'hF, d & 5'h1F,
                         amt & 16'hFFFF, oy & 16'h3FFF, om & 4'hF, od & 5'h1F);
    pending_dates.insert(pending_dates.size(), exp_w);
    start <= 1'b0;
  endtask

  // Directed edge cases: extremes, leap rules, clamps.
  task automatic test_directed;
    send_date(OP_ADD_DAYS, 2024, 12, 31, 1, 1, 1, 1);       // leap Dec 31 wrap
    send_date(OP_ADD_DAYS, 2000, 2, 28, 1, 1, 1, 1);        // 400-year leap
    send_date(OP_ADD_DAYS, 1900, 2, 28, 1, 1, 1, 1);        // 100-year non-leap
    send_date(OP_ADD_DAYS, 1, 1, 1, 0, 1, 1, 1);
    send_date(OP_ADD_DAYS, 9999, 12, 31, 1, 1, 1, 1);       // overflow
    send_date(OP_ADD_DAYS, 9900, 1, 1, 65535, 1, 1, 1);     // max amount
    send_date(OP_ADD_MONTHS, 2023, 1, 31, 1, 1, 1, 1);      // clamp to Feb 28
    send_date(OP_ADD_MONTHS, 2024, 1, 31, 1, 1, 1, 1);      // clamp to Feb 29
    send_date(OP_ADD_MONTHS, 2023, 12, 15, 1, 1, 1, 1);     // month wrap
    send_date(OP_ADD_MONTHS, 9999, 12, 1, 1, 1, 1, 1);
    send_date(OP_ADD_MONTHS, 1, 1, 1, 65535, 1, 1, 1);
    send_date(OP_ADD_YEARS, 2024, 2, 29, 1, 1, 1, 1);       // leap clamp
    send_date(OP_ADD_YEARS, 1, 6, 15, 65535, 1, 1, 1);
    send_date(OP_ADD_YEARS, 9998, 3, 3, 1, 1, 1, 1);
    send_date(OP_DIFF, 1, 1, 1, 0, 9999, 12, 31);           // widest span
    send_date(OP_DIFF, 9999, 12, 31, 0, 1, 1, 1);
    send_date(OP_DIFF, 2000, 3, 1, 0, 2000, 2, 28);
    send_date(OP_DIFF, 0, 0, 0, 0, 0, 0, 0);                // all clamps low
    send_date(OP_DIFF, 16383, 15, 31, 65535, 16383, 15, 31); // all clamps high
    send_date(OP_ADD_DAYS, 2023, 4, 31, 0, 1, 1, 1);        // day past month end
    send_date(OP_ADD_YEARS, 0, 0, 0, 0, 0, 0, 0);
    send_date(OP_ADD_MONTHS, 10000, 13, 30, 0, 1, 1, 1);
  endtask

  // Mostly valid dates with small amounts; a share of raw noise and
  // full-range amounts to hit clamps and overflow.
  task automatic test_random(int unsigned count);
    int unsigned y, m, d, amt, oy, om, od, sel;
    for (int unsigned i = 0; i < count; i++) begin
      sel = $urandom_range(0, 9);
      if (sel < 7) begin
        y  = $urandom_range(1, 9999);
        m  = $urandom_range(1, 12);
        d  = $urandom_range(1, month_days(y, m));
        oy = $urandom_range(1, 9999);
        om = $urandom_range(1, 12);
        od = $urandom_range(1, month_days(oy, om));
      end else begin
        y  = $urandom_range(0, 16383);
        m  = $urandom_range(0, 15);
        d  = $urandom_range(0, 31);
        oy = $urandom_range(0, 16383);
        om = $urandom_range(0, 15);
        od = $urandom_range(0, 31);
      end
      amt = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                         : $urandom_range(0, 800);
      send_date(op_t'($urandom_range(0, 3)), y, m, d, amt, oy, om, od);
    end
  endtask

  // ---- result checking ----
  always @(posedge clk) begin
    date_word_t exp_w;
    if (rst_n && out_valid) begin
      if (pending_dates.size() == 0) begin
        $error("unexpected result word");
        err_cnt++;
      end else begin
        exp_w = pending_dates.pop_front();
        if (out_result_year !== exp_w.year) begin
          $error("result_year exp %0d got %0d", exp_w.year, out_result_year);
          err_cnt++;
        end
        if (out_result_month !== exp_w.month) begin
          $error("result_month exp %0d got %0d", exp_w.month, out_result_month);
          err_cnt++;
        end
        if (out_result_day !== exp_w.day) begin
          $error("result_day exp %0d got %0d", exp_w.day, out_result_day);
          err_cnt++;
        end
        if (out_day_difference !== exp_w.diff) begin
          $error("day_difference exp %0d got %0d", exp_w.diff, out_day_difference);
          err_cnt++;
        end
        if (out_date_valid !== exp_w.valid) begin
          $error("date_valid exp %0d got %0d", exp_w.valid, out_date_valid);
          err_cnt++;
        end
        if (out_overflow !== exp_w.ovf) begin
          $error("overflow exp %0d got %0d", exp_w.ovf, out_overflow);
          err_cnt++;
        end
      end
    end
  end

  // Watchdog: count cycles with no word moving on either side.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("gregorian_date_arithmetic_core_tb: errors");
      $finish;
    end
  end

  initial begin
    err_cnt        = 0;
    idle_cycles    = 0;
    rst_n          = 1'b0;
    start          = 1'b0;
    in_operation   = '0;
    in_base_year   = '0;
    in_base_month  = '0;
    in_base_day    = '0;
    in_amount      = '0;
    in_other_year  = '0;
    in_other_month = '0;
    in_other_day   = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(750);
    // Drain outstanding words, then idle for DRAIN_CYCLES before reporting.
    while (pending_dates.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("gregorian_date_arithmetic_core_tb: clean");
    end else begin
      $display("gregorian_date_arithmetic_core_tb: errors");
    end
    $finish;
  end

endmodule
